// ===== rtl/sme_pkg.sv =====
// ----------------------------------------------------------------------------
// sme_pkg
// Shared constants, types and operation codes of the stack machine execute unit.
// ----------------------------------------------------------------------------
package sme_pkg;

    localparam int STACK_DEPTH = 1024;
    localparam int CODE_DEPTH  = 256;
    localparam int LEVEL_COUNT = 11;
    localparam int MARK_SIZE   = 3;
    localparam int LINK_SLOT   = 2;

    localparam int STACK_AW = $clog2(STACK_DEPTH);
    localparam int LEVEL_AW = $clog2(LEVEL_COUNT);
    localparam int PC_W     = $clog2(CODE_DEPTH);
    localparam int WORD_W   = 32;
    localparam int IDX_W    = WORD_W + 2;
    localparam int ACT_W    = 6;
    localparam int LEV_W    = 4;
    localparam int OPD_W    = 11;
    localparam int MODE_W   = 2;
    localparam int DCNT_W   = $clog2(WORD_W);
    localparam int IN_W     = 56;
    localparam int OUT_W    = 48;

    typedef logic signed [IDX_W-1:0] idx_t;
    typedef logic [WORD_W-1:0]       word_t;
    typedef logic [STACK_AW-1:0]     sidx_t;

    localparam logic [ACT_W-1:0] OP_LIT  = 6'd0;
    localparam logic [ACT_W-1:0] OP_LOD  = 6'd1;
    localparam logic [ACT_W-1:0] OP_ILOD = 6'd2;
    localparam logic [ACT_W-1:0] OP_LODA = 6'd3;
    localparam logic [ACT_W-1:0] OP_LODT = 6'd4;
    localparam logic [ACT_W-1:0] OP_STO  = 6'd5;
    localparam logic [ACT_W-1:0] OP_LODB = 6'd6;
    localparam logic [ACT_W-1:0] OP_CPYB = 6'd7;
    localparam logic [ACT_W-1:0] OP_JMP  = 6'd8;
    localparam logic [ACT_W-1:0] OP_JPC  = 6'd9;
    localparam logic [ACT_W-1:0] OP_RED  = 6'd10;
    localparam logic [ACT_W-1:0] OP_WRT  = 6'd11;
    localparam logic [ACT_W-1:0] OP_CAL  = 6'd12;
    localparam logic [ACT_W-1:0] OP_RETP = 6'd13;
    localparam logic [ACT_W-1:0] OP_ENDP = 6'd14;
    localparam logic [ACT_W-1:0] OP_UDIS = 6'd15;
    localparam logic [ACT_W-1:0] OP_OPAC = 6'd16;
    localparam logic [ACT_W-1:0] OP_ENTP = 6'd17;
    localparam logic [ACT_W-1:0] OP_ANDS = 6'd18;
    localparam logic [ACT_W-1:0] OP_ORS  = 6'd19;
    localparam logic [ACT_W-1:0] OP_NOTS = 6'd20;
    localparam logic [ACT_W-1:0] OP_IMOD = 6'd21;
    localparam logic [ACT_W-1:0] OP_MUS  = 6'd22;
    localparam logic [ACT_W-1:0] OP_ADD  = 6'd23;
    localparam logic [ACT_W-1:0] OP_SUB  = 6'd24;
    localparam logic [ACT_W-1:0] OP_MULT = 6'd25;
    localparam logic [ACT_W-1:0] OP_IDIV = 6'd26;
    localparam logic [ACT_W-1:0] OP_EQ   = 6'd27;
    localparam logic [ACT_W-1:0] OP_NE   = 6'd28;
    localparam logic [ACT_W-1:0] OP_LS   = 6'd29;
    localparam logic [ACT_W-1:0] OP_LE   = 6'd30;
    localparam logic [ACT_W-1:0] OP_GT   = 6'd31;
    localparam logic [ACT_W-1:0] OP_GE   = 6'd32;

    localparam logic [OPD_W-1:0] MODE_MAX = 11'd2;

endpackage

// ===== rtl/sme_ram.sv =====
// ----------------------------------------------------------------------------
// sme_ram
// Generic single-port synchronous RAM with registered read data.
// ----------------------------------------------------------------------------
module sme_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     en,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (en) begin
            if (we) begin
                mem[addr] <= wdata;
            end
            rdata <= mem[addr];
        end
    end

endmodule

// ===== rtl/stack_machine_execute_unit.sv =====
// ----------------------------------------------------------------------------
// stack_machine_execute_unit
// Executes one integer p-code instruction per input word against a data stack
// memory, a display of frame bases and the top, base, old-top and pc registers.
// ----------------------------------------------------------------------------
// After reset all 1024 words of the stack memory are cleared, during which no
// word is accepted. Each instruction then runs through a sequencer around the
// single-port stack RAM, one stack access per cycle. Literals, address loads,
// jumps, mark, entry, halt and read or write with a mode above 2 finish in the
// decode state; the others go on through further access states, block load and
// copy through a read and a write per word, display update through a read per
// level walked, and divide and modulo through a bit-serial divider. The
// sequencer goes back to idle as it raises m_tvalid, or waits in the done state
// while the previous result has not been taken. The result sits in an output
// register, so the next word is taken while it waits.
// ----------------------------------------------------------------------------
module stack_machine_execute_unit (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_tvalid,
    output logic                     s_tready,
    // action[5:0], level[9:6], operand[20:10], read_value[52:21]
    input  logic [sme_pkg::IN_W-1:0] s_tdata,
    output logic                     m_tvalid,
    input  logic                     m_tready,
    // next_pc[7:0], write_valid[8], write_mode[10:9], write_value[42:11],
    // halted[43], fault[44]
    output logic [sme_pkg::OUT_W-1:0] m_tdata
);

    localparam int AW = sme_pkg::STACK_AW;

    typedef enum logic [3:0] {
        ST_CLEAR, ST_IDLE, ST_DEC, ST_S1, ST_S2, ST_S3, ST_S4,
        ST_LRD, ST_LWR, ST_UD, ST_UDW, ST_DIV, ST_DIVEND, ST_DONE
    } state_t;

    function automatic logic bad(input sme_pkg::idx_t v);
        return (v < 0) || (v > $signed(sme_pkg::IDX_W'(sme_pkg::STACK_DEPTH - 1)));
    endfunction

    function automatic sme_pkg::idx_t zx(input sme_pkg::sidx_t v);
        return $signed({{(sme_pkg::IDX_W-AW){1'b0}}, v});
    endfunction

    function automatic sme_pkg::idx_t zo(input logic [sme_pkg::OPD_W-1:0] v);
        return $signed({{(sme_pkg::IDX_W-sme_pkg::OPD_W){1'b0}}, v});
    endfunction

    function automatic sme_pkg::idx_t sx(input sme_pkg::word_t w);
        return $signed({{(sme_pkg::IDX_W-sme_pkg::WORD_W){w[sme_pkg::WORD_W-1]}}, w});
    endfunction

    state_t                         state_reg, state_next;
    sme_pkg::sidx_t                 clr_cnt_reg, clr_cnt_next;
    logic [sme_pkg::ACT_W-1:0]      act_reg, act_next;
    logic [sme_pkg::LEV_W-1:0]      lev_reg, lev_next;
    logic [sme_pkg::OPD_W-1:0]      opd_reg, opd_next;
    sme_pkg::word_t                 rv_reg, rv_next;
    logic [sme_pkg::PC_W-1:0]       pc_reg, pc_next;
    sme_pkg::sidx_t                 top_reg, top_next;
    sme_pkg::sidx_t                 base_reg, base_next;
    sme_pkg::sidx_t                 saved_reg, saved_next;
    logic                           stopped_reg, stopped_next;
    sme_pkg::sidx_t                 disp_reg [sme_pkg::LEVEL_COUNT];
    sme_pkg::sidx_t                 disp_next [sme_pkg::LEVEL_COUNT];
    sme_pkg::idx_t                  h1_reg, h1_next;
    sme_pkg::idx_t                  h2_reg, h2_next;
    logic [sme_pkg::OPD_W-1:0]      cnt_reg, cnt_next;
    sme_pkg::word_t                 x_reg, x_next;
    sme_pkg::word_t                 res_reg, res_next;
    logic                           flt_reg, flt_next;
    logic                           wv_reg, wv_next;
    logic [sme_pkg::MODE_W-1:0]     wm_reg, wm_next;
    sme_pkg::word_t                 wval_reg, wval_next;
    logic                           rd_oor_reg, rd_oor_next;
    sme_pkg::word_t                 div_q_reg, div_q_next;
    sme_pkg::word_t                 div_r_reg, div_r_next;
    sme_pkg::word_t                 div_d_reg, div_d_next;
    logic [sme_pkg::DCNT_W-1:0]     div_cnt_reg, div_cnt_next;
    logic                           sa_reg, sa_next;
    logic                           sb_reg, sb_next;
    logic                           m_valid_reg, m_valid_next;
    logic [sme_pkg::OUT_W-1:0]      m_data_reg, m_data_next;

    logic                           mem_en, mem_we;
    sme_pkg::sidx_t                 mem_addr;
    sme_pkg::word_t                 mem_wdata, mem_q;

    sme_ram #(
        .WIDTH (sme_pkg::WORD_W),
        .DEPTH (sme_pkg::STACK_DEPTH)
    ) u_stack (
        .clk   (aclk),
        .en    (mem_en),
        .we    (mem_we),
        .addr  (mem_addr),
        .wdata (mem_wdata),
        .rdata (mem_q)
    );

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    sme_pkg::word_t  word;
    logic            lev_bad;
    sme_pkg::sidx_t  dval;
    sme_pkg::idx_t   top_m1, top_m2, top_p1, top_p3;

    assign word    = rd_oor_reg ? '0 : mem_q;
    assign lev_bad = (lev_reg >= sme_pkg::LEV_W'(sme_pkg::LEVEL_COUNT));
    assign dval    = lev_bad ? '0 : disp_reg[sme_pkg::LEVEL_AW'(lev_reg)];
    assign top_m1  = zx(top_reg) - 1;
    assign top_m2  = zx(top_reg) - 2;
    assign top_p1  = zx(top_reg) + 1;
    assign top_p3  = zx(top_reg) + sme_pkg::IDX_W'(sme_pkg::MARK_SIZE);

    always_comb begin
        logic            acc_rd, acc_wr, do_push, set_top;
        sme_pkg::idx_t   acc_idx, top_val, ebase;
        sme_pkg::word_t  acc_wdata, push_val, dq, dr, abs_a;
        logic [sme_pkg::WORD_W:0] rs, diff;

        acc_rd    = 1'b0;
        acc_wr    = 1'b0;
        do_push   = 1'b0;
        set_top   = 1'b0;
        acc_idx   = '0;
        top_val   = '0;
        ebase     = '0;
        acc_wdata = '0;
        push_val  = '0;
        dq        = '0;
        dr        = '0;
        abs_a     = '0;
        rs        = '0;
        diff      = '0;

        state_next   = state_reg;
        clr_cnt_next = clr_cnt_reg;
        act_next     = act_reg;
        lev_next     = lev_reg;
        opd_next     = opd_reg;
        rv_next      = rv_reg;
        pc_next      = pc_reg;
        top_next     = top_reg;
        base_next    = base_reg;
        saved_next   = saved_reg;
        stopped_next = stopped_reg;
        disp_next    = disp_reg;
        h1_next      = h1_reg;
        h2_next      = h2_reg;
        cnt_next     = cnt_reg;
        x_next       = x_reg;
        res_next     = res_reg;
        flt_next     = flt_reg;
        wv_next      = wv_reg;
        wm_next      = wm_reg;
        wval_next    = wval_reg;
        div_q_next   = div_q_reg;
        div_r_next   = div_r_reg;
        div_d_next   = div_d_reg;
        div_cnt_next = div_cnt_reg;
        sa_next      = sa_reg;
        sb_next      = sb_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;

        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_CLEAR: begin
                acc_wr       = 1'b1;
                acc_idx      = zx(clr_cnt_reg);
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == AW'(sme_pkg::STACK_DEPTH - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_tvalid) begin
                    act_next  = s_tdata[5:0];
                    lev_next  = s_tdata[9:6];
                    opd_next  = s_tdata[20:10];
                    rv_next   = s_tdata[52:21];
                    flt_next  = 1'b0;
                    wv_next   = 1'b0;
                    wm_next   = '0;
                    wval_next = '0;
                    if (!stopped_reg) begin
                        pc_next = pc_reg + 1'b1;
                    end
                    state_next = ST_DEC;
                end
            end
            ST_DEC: begin
                state_next = ST_DONE;
                if (!stopped_reg) begin
                    unique case (act_reg)
                        sme_pkg::OP_LIT: begin
                            do_push  = 1'b1;
                            push_val = sme_pkg::WORD_W'(opd_reg);
                        end
                        sme_pkg::OP_LOD, sme_pkg::OP_ILOD: begin
                            if (lev_bad) flt_next = 1'b1;
                            acc_rd     = 1'b1;
                            acc_idx    = zx(dval) + zo(opd_reg);
                            state_next = ST_S1;
                        end
                        sme_pkg::OP_LODA: begin
                            if (lev_bad) flt_next = 1'b1;
                            do_push  = 1'b1;
                            push_val = sme_pkg::WORD_W'(dval) + sme_pkg::WORD_W'(opd_reg);
                        end
                        sme_pkg::OP_LODT, sme_pkg::OP_LODB, sme_pkg::OP_JPC,
                        sme_pkg::OP_NOTS, sme_pkg::OP_MUS: begin
                            acc_rd     = 1'b1;
                            acc_idx    = zx(top_reg);
                            state_next = ST_S1;
                        end
                        sme_pkg::OP_STO, sme_pkg::OP_CPYB: begin
                            acc_rd     = 1'b1;
                            acc_idx    = top_m1;
                            state_next = ST_S1;
                        end
                        sme_pkg::OP_JMP: begin
                            pc_next = opd_reg[sme_pkg::PC_W-1:0];
                        end
                        sme_pkg::OP_RED, sme_pkg::OP_WRT: begin
                            if (opd_reg <= sme_pkg::MODE_MAX) begin
                                acc_rd     = 1'b1;
                                acc_idx    = zx(top_reg);
                                state_next = ST_S1;
                            end else begin
                                set_top = 1'b1;
                                top_val = top_m1;
                            end
                        end
                        sme_pkg::OP_CAL: begin
                            if (lev_bad) flt_next = 1'b1;
                            acc_wr     = 1'b1;
                            acc_idx    = zx(saved_reg) + 1;
                            acc_wdata  = sme_pkg::WORD_W'(pc_reg);
                            state_next = ST_S1;
                        end
                        sme_pkg::OP_RETP: begin
                            set_top    = 1'b1;
                            top_val    = zx(base_reg) - 1;
                            state_next = ST_S1;
                        end
                        sme_pkg::OP_ENDP: begin
                            stopped_next = 1'b1;
                        end
                        sme_pkg::OP_UDIS: begin
                            h1_next    = zx(base_reg);
                            cnt_next   = opd_reg;
                            state_next = ST_UD;
                        end
                        sme_pkg::OP_OPAC: begin
                            saved_next = top_reg;
                            set_top    = 1'b1;
                            top_val    = top_p3;
                        end
                        sme_pkg::OP_ENTP: begin
                            ebase = zx(saved_reg) + 1;
                            if (bad(ebase)) flt_next = 1'b1;
                            base_next = ebase[AW-1:0];
                            if (lev_bad) begin
                                flt_next = 1'b1;
                            end else begin
                                disp_next[sme_pkg::LEVEL_AW'(lev_reg)] = ebase[AW-1:0];
                            end
                            set_top = 1'b1;
                            top_val = zx(saved_reg) + zo(opd_reg);
                        end
                        sme_pkg::OP_ANDS, sme_pkg::OP_ORS, sme_pkg::OP_IMOD,
                        sme_pkg::OP_ADD, sme_pkg::OP_SUB, sme_pkg::OP_MULT,
                        sme_pkg::OP_IDIV, sme_pkg::OP_EQ, sme_pkg::OP_NE,
                        sme_pkg::OP_LS, sme_pkg::OP_LE, sme_pkg::OP_GT,
                        sme_pkg::OP_GE: begin
                            set_top    = 1'b1;
                            top_val    = top_m1;
                            state_next = ST_S1;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_S1: begin
                state_next = ST_DONE;
                unique case (act_reg)
                    sme_pkg::OP_LOD: begin
                        do_push  = 1'b1;
                        push_val = word;
                    end
                    sme_pkg::OP_ILOD, sme_pkg::OP_LODT: begin
                        acc_rd     = 1'b1;
                        acc_idx    = sx(word);
                        state_next = ST_S2;
                    end
                    sme_pkg::OP_STO: begin
                        x_next     = word;
                        acc_rd     = 1'b1;
                        acc_idx    = zx(top_reg);
                        state_next = ST_S2;
                    end
                    sme_pkg::OP_LODB: begin
                        h1_next    = sx(word);
                        set_top    = 1'b1;
                        top_val    = top_m1;
                        cnt_next   = '0;
                        state_next = ST_LRD;
                    end
                    sme_pkg::OP_CPYB: begin
                        h1_next    = sx(word);
                        acc_rd     = 1'b1;
                        acc_idx    = zx(top_reg);
                        state_next = ST_S2;
                    end
                    sme_pkg::OP_JPC: begin
                        if (word == '0) pc_next = opd_reg[sme_pkg::PC_W-1:0];
                        set_top = 1'b1;
                        top_val = top_m1;
                    end
                    sme_pkg::OP_RED: begin
                        acc_wr    = 1'b1;
                        acc_idx   = sx(word);
                        acc_wdata = rv_reg;
                        set_top   = 1'b1;
                        top_val   = top_m1;
                    end
                    sme_pkg::OP_WRT: begin
                        wv_next   = 1'b1;
                        wm_next   = opd_reg[sme_pkg::MODE_W-1:0];
                        wval_next = word;
                        set_top   = 1'b1;
                        top_val   = top_m1;
                    end
                    sme_pkg::OP_CAL: begin
                        acc_wr     = 1'b1;
                        acc_idx    = zx(saved_reg) + sme_pkg::IDX_W'(sme_pkg::LINK_SLOT);
                        acc_wdata  = sme_pkg::WORD_W'(dval);
                        state_next = ST_S2;
                    end
                    sme_pkg::OP_RETP: begin
                        acc_rd     = 1'b1;
                        acc_idx    = top_p1;
                        state_next = ST_S2;
                    end
                    sme_pkg::OP_NOTS: begin
                        acc_wr    = 1'b1;
                        acc_idx   = zx(top_reg);
                        acc_wdata = ~word;
                    end
                    sme_pkg::OP_MUS: begin
                        acc_wr    = 1'b1;
                        acc_idx   = zx(top_reg);
                        acc_wdata = '0 - word;
                    end
                    default: begin
                        acc_rd     = 1'b1;
                        acc_idx    = zx(top_reg);
                        state_next = ST_S2;
                    end
                endcase
            end
            ST_S2: begin
                state_next = ST_DONE;
                unique case (act_reg)
                    sme_pkg::OP_ILOD: begin
                        do_push  = 1'b1;
                        push_val = word;
                    end
                    sme_pkg::OP_LODT: begin
                        acc_wr    = 1'b1;
                        acc_idx   = zx(top_reg);
                        acc_wdata = word;
                    end
                    sme_pkg::OP_STO: begin
                        acc_wr    = 1'b1;
                        acc_idx   = sx(x_reg);
                        acc_wdata = word;
                        set_top   = 1'b1;
                        top_val   = top_m2;
                    end
                    sme_pkg::OP_CPYB: begin
                        h2_next    = sx(word);
                        cnt_next   = '0;
                        set_top    = 1'b1;
                        top_val    = top_m2;
                        state_next = ST_LRD;
                    end
                    sme_pkg::OP_CAL: begin
                        acc_wr    = 1'b1;
                        acc_idx   = zx(saved_reg) + sme_pkg::IDX_W'(sme_pkg::MARK_SIZE);
                        acc_wdata = sme_pkg::WORD_W'(base_reg);
                        pc_next   = opd_reg[sme_pkg::PC_W-1:0];
                    end
                    sme_pkg::OP_RETP: begin
                        pc_next    = word[sme_pkg::PC_W-1:0];
                        acc_rd     = 1'b1;
                        acc_idx    = top_p3;
                        state_next = ST_S3;
                    end
                    default: begin
                        x_next     = word;
                        acc_rd     = 1'b1;
                        acc_idx    = top_p1;
                        state_next = ST_S3;
                    end
                endcase
            end
            ST_S3: begin
                state_next = ST_S4;
                unique case (act_reg)
                    sme_pkg::OP_RETP: begin
                        ebase = sx(word);
                        if (bad(ebase)) flt_next = 1'b1;
                        base_next  = ebase[AW-1:0];
                        state_next = ST_DONE;
                    end
                    sme_pkg::OP_ANDS: res_next = x_reg & word;
                    sme_pkg::OP_ORS:  res_next = x_reg | word;
                    sme_pkg::OP_ADD:  res_next = x_reg + word;
                    sme_pkg::OP_SUB:  res_next = x_reg - word;
                    sme_pkg::OP_MULT: res_next = x_reg * word;
                    sme_pkg::OP_EQ:   res_next = sme_pkg::WORD_W'(x_reg == word);
                    sme_pkg::OP_NE:   res_next = sme_pkg::WORD_W'(x_reg != word);
                    sme_pkg::OP_LS:
                        res_next = sme_pkg::WORD_W'($signed(x_reg) < $signed(word));
                    sme_pkg::OP_LE:
                        res_next = sme_pkg::WORD_W'($signed(x_reg) <= $signed(word));
                    sme_pkg::OP_GT:
                        res_next = sme_pkg::WORD_W'($signed(x_reg) > $signed(word));
                    sme_pkg::OP_GE:
                        res_next = sme_pkg::WORD_W'($signed(x_reg) >= $signed(word));
                    sme_pkg::OP_IMOD, sme_pkg::OP_IDIV: begin
                        if (word == '0) begin
                            flt_next = 1'b1;
                            res_next = '0;
                        end else begin
                            abs_a        = x_reg[sme_pkg::WORD_W-1] ? '0 - x_reg : x_reg;
                            sa_next      = x_reg[sme_pkg::WORD_W-1];
                            sb_next      = word[sme_pkg::WORD_W-1];
                            div_q_next   = abs_a;
                            div_r_next   = '0;
                            div_d_next   = word[sme_pkg::WORD_W-1] ? '0 - word : word;
                            div_cnt_next = '0;
                            state_next   = ST_DIV;
                        end
                    end
                    default: state_next = ST_DONE;
                endcase
            end
            ST_S4: begin
                acc_wr     = 1'b1;
                acc_idx    = zx(top_reg);
                acc_wdata  = res_reg;
                state_next = ST_DONE;
            end
            ST_LRD: begin
                if (cnt_reg < opd_reg) begin
                    acc_rd     = 1'b1;
                    acc_idx    = ((act_reg == sme_pkg::OP_LODB) ? h1_reg : h2_reg)
                                 + zo(cnt_reg);
                    state_next = ST_LWR;
                end else begin
                    state_next = ST_DONE;
                end
            end
            ST_LWR: begin
                cnt_next   = cnt_reg + 1'b1;
                state_next = ST_LRD;
                if (act_reg == sme_pkg::OP_LODB) begin
                    do_push  = 1'b1;
                    push_val = word;
                end else begin
                    acc_wr    = 1'b1;
                    acc_idx   = h1_reg + zo(cnt_reg);
                    acc_wdata = word;
                end
            end
            ST_UD: begin
                if (cnt_reg > sme_pkg::OPD_W'(lev_reg)) begin
                    if (bad(h1_reg)) flt_next = 1'b1;
                    if (cnt_reg < sme_pkg::OPD_W'(sme_pkg::LEVEL_COUNT)) begin
                        disp_next[sme_pkg::LEVEL_AW'(cnt_reg)] = h1_reg[AW-1:0];
                    end else begin
                        flt_next = 1'b1;
                    end
                    acc_rd     = 1'b1;
                    acc_idx    = h1_reg + sme_pkg::IDX_W'(sme_pkg::LINK_SLOT);
                    state_next = ST_UDW;
                end else begin
                    state_next = ST_DONE;
                end
            end
            ST_UDW: begin
                h1_next    = sx(word);
                cnt_next   = cnt_reg - 1'b1;
                state_next = ST_UD;
            end
            ST_DIV: begin
                rs   = {div_r_reg, div_q_reg[sme_pkg::WORD_W-1]};
                diff = rs - {1'b0, div_d_reg};
                if (!diff[sme_pkg::WORD_W]) begin
                    div_r_next = diff[sme_pkg::WORD_W-1:0];
                    div_q_next = {div_q_reg[sme_pkg::WORD_W-2:0], 1'b1};
                end else begin
                    div_r_next = rs[sme_pkg::WORD_W-1:0];
                    div_q_next = {div_q_reg[sme_pkg::WORD_W-2:0], 1'b0};
                end
                div_cnt_next = div_cnt_reg + 1'b1;
                if (div_cnt_reg == sme_pkg::DCNT_W'(sme_pkg::WORD_W - 1)) begin
                    state_next = ST_DIVEND;
                end
            end
            ST_DIVEND: begin
                dq = (sa_reg ^ sb_reg) ? '0 - div_q_reg : div_q_reg;
                dr = sa_reg ? '0 - div_r_reg : div_r_reg;
                res_next   = (act_reg == sme_pkg::OP_IDIV) ? dq : dr;
                state_next = ST_S4;
            end
            ST_DONE: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = {3'b000, flt_reg, stopped_reg, wval_reg, wm_reg,
                                    wv_reg, pc_reg};
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase

        if (do_push) begin
            set_top   = 1'b1;
            top_val   = top_p1;
            acc_wr    = 1'b1;
            acc_idx   = zx(top_p1[AW-1:0]);
            acc_wdata = push_val;
        end
        if (set_top) begin
            top_next = top_val[AW-1:0];
            if (bad(top_val)) flt_next = 1'b1;
        end

        mem_en      = (acc_rd || acc_wr) && !bad(acc_idx);
        mem_we      = acc_wr && !bad(acc_idx);
        mem_addr    = acc_idx[AW-1:0];
        mem_wdata   = acc_wdata;
        rd_oor_next = acc_rd && bad(acc_idx);
        if ((acc_rd || acc_wr) && bad(acc_idx)) flt_next = 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            clr_cnt_reg <= '0;
            pc_reg      <= '0;
            top_reg     <= '0;
            base_reg    <= '0;
            saved_reg   <= '0;
            stopped_reg <= 1'b0;
            disp_reg    <= '{default: '0};
            m_valid_reg <= 1'b0;
            rd_oor_reg  <= 1'b0;
        end else begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
            pc_reg      <= pc_next;
            top_reg     <= top_next;
            base_reg    <= base_next;
            saved_reg   <= saved_next;
            stopped_reg <= stopped_next;
            disp_reg    <= disp_next;
            m_valid_reg <= m_valid_next;
            rd_oor_reg  <= rd_oor_next;
        end
        act_reg     <= act_next;
        lev_reg     <= lev_next;
        opd_reg     <= opd_next;
        rv_reg      <= rv_next;
        h1_reg      <= h1_next;
        h2_reg      <= h2_next;
        cnt_reg     <= cnt_next;
        x_reg       <= x_next;
        res_reg     <= res_next;
        flt_reg     <= flt_next;
        wv_reg      <= wv_next;
        wm_reg      <= wm_next;
        wval_reg    <= wval_next;
        div_q_reg   <= div_q_next;
        div_r_reg   <= div_r_next;
        div_d_reg   <= div_d_next;
        div_cnt_reg <= div_cnt_next;
        sa_reg      <= sa_next;
        sb_reg      <= sb_next;
        m_data_reg  <= m_data_next;
    end

    // an accepted word always takes the sequencer out of idle
    a_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input accepted on consecutive cycles");

    // a halted machine never reports a write
    a_halt_no_write: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[43]) |-> !m_tdata[8])
        else $error("write reported while halted");

    // the divider never runs on a zero divisor
    a_div_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DIV) |-> (div_d_reg != '0))
        else $error("divider started with zero divisor");

    // once stopped, accepting a word leaves the pc alone
    a_halt_pc: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && stopped_reg) |=> (pc_reg == $past(pc_reg)))
        else $error("pc moved while halted");

endmodule

// ===== bench/stack_machine_execute_unit_test.sv =====
// ----------------------------------------------------------------------------
// stack_machine_execute_unit_test
// Drives p-code instruction words into the execute unit and checks each result
// against a software model of the stack machine, or against the pc and fault
// a directed row gives. A short directed table comes first, then random programs
// biased toward valid stack use, then end-program and a few halted steps.
// ----------------------------------------------------------------------------
module stack_machine_execute_unit_test;

    localparam int STALL_LIMIT = 40000;

    typedef struct {
        logic [7:0]  pc;
        logic        wv;
        logic [1:0]  wm;
        logic [31:0] wval;
        logic        halt;
        logic        flt;
    } result_t;

    typedef struct {
        logic [5:0]  act;
        logic [3:0]  lev;
        logic [10:0] opd;
        logic [31:0] rv;
        bit          typed;
        result_t     res;
    } row_t;

    logic                        aclk = 0;
    logic                        aresetn = 0;
    logic                        s_tvalid = 0;
    logic                        s_tready;
    logic [sme_pkg::IN_W-1:0]    s_tdata = '0;
    logic                        m_tvalid;
    logic                        m_tready = 0;
    logic [sme_pkg::OUT_W-1:0]   m_tdata;

    stack_machine_execute_unit dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    // machine model state
    logic [31:0] mem_words [0:sme_pkg::STACK_DEPTH-1];
    longint      disp_base [0:sme_pkg::LEVEL_COUNT-1];
    longint      top_q, base_q, old_top_q, pc_q;
    bit          stop_q, flt_q;

    result_t     pending_results [$];
    row_t        cur_word;
    int          words_in = 0;
    int          errors = 0;
    int          quiet_cycles = 0;
    bit          no_idle = 0;

    function automatic longint sx(logic [31:0] v);
        return longint'($signed(v));
    endfunction

    function automatic logic [31:0] mem_rd(longint i);
        if (i < 0 || i >= sme_pkg::STACK_DEPTH) begin
            flt_q = 1;
            return 32'd0;
        end
        return mem_words[i];
    endfunction

    function automatic void mem_wr(longint i, logic [31:0] v);
        if (i < 0 || i >= sme_pkg::STACK_DEPTH) flt_q = 1;
        else mem_words[i] = v;
    endfunction

    function automatic longint wrap_idx(longint v);
        if (v < 0 || v >= sme_pkg::STACK_DEPTH) begin
            flt_q = 1;
            v = v % sme_pkg::STACK_DEPTH;
            if (v < 0) v += sme_pkg::STACK_DEPTH;
        end
        return v;
    endfunction

    function automatic longint wrap_pc(longint v);
        v = v % sme_pkg::CODE_DEPTH;
        if (v < 0) v += sme_pkg::CODE_DEPTH;
        return v;
    endfunction

    function automatic longint disp_rd(longint l);
        if (l >= sme_pkg::LEVEL_COUNT) begin
            flt_q = 1;
            return 0;
        end
        return disp_base[l];
    endfunction

    function automatic void disp_wr(longint l, longint v);
        if (l >= sme_pkg::LEVEL_COUNT) flt_q = 1;
        else disp_base[l] = v;
    endfunction

    function automatic void push_word(logic [31:0] v);
        top_q = wrap_idx(top_q + 1);
        mem_wr(top_q, v);
    endfunction

    function automatic result_t execute_word(logic [5:0] act, logic [3:0] lev,
                                             logic [10:0] opd, logic [31:0] rv);
        result_t     r;
        longint      a, b, h1, h2, h3;
        logic [31:0] v;
        r = '{default: 0};
        flt_q = 0;
        if (!stop_q) begin
            pc_q = wrap_pc(pc_q + 1);
            unique case (act)
                sme_pkg::OP_LIT:  push_word(32'(opd));
                sme_pkg::OP_LOD:  push_word(mem_rd(disp_rd(lev) + opd));
                sme_pkg::OP_ILOD: push_word(mem_rd(sx(mem_rd(disp_rd(lev) + opd))));
                sme_pkg::OP_LODA: push_word(32'(disp_rd(lev) + opd));
                sme_pkg::OP_LODT: mem_wr(top_q, mem_rd(sx(mem_rd(top_q))));
                sme_pkg::OP_STO: begin
                    mem_wr(sx(mem_rd(top_q - 1)), mem_rd(top_q));
                    top_q = wrap_idx(top_q - 2);
                end
                sme_pkg::OP_LODB: begin
                    h1 = sx(mem_rd(top_q));
                    top_q = wrap_idx(top_q - 1);
                    for (longint k = 0; k < opd; k++) push_word(mem_rd(h1 + k));
                end
                sme_pkg::OP_CPYB: begin
                    h1 = sx(mem_rd(top_q - 1));
                    h2 = sx(mem_rd(top_q));
                    for (longint k = 0; k < opd; k++) mem_wr(h1 + k, mem_rd(h2 + k));
                    top_q = wrap_idx(top_q - 2);
                end
                sme_pkg::OP_JMP: pc_q = wrap_pc(opd);
                sme_pkg::OP_JPC: begin
                    if (mem_rd(top_q) == 0) pc_q = wrap_pc(opd);
                    top_q = wrap_idx(top_q - 1);
                end
                sme_pkg::OP_RED: begin
                    if (opd <= sme_pkg::MODE_MAX) mem_wr(sx(mem_rd(top_q)), rv);
                    top_q = wrap_idx(top_q - 1);
                end
                sme_pkg::OP_WRT: begin
                    if (opd <= sme_pkg::MODE_MAX) begin
                        r.wv = 1;
                        r.wm = opd[1:0];
                        r.wval = mem_rd(top_q);
                    end
                    top_q = wrap_idx(top_q - 1);
                end
                sme_pkg::OP_CAL: begin
                    mem_wr(old_top_q + 1, 32'(pc_q));
                    mem_wr(old_top_q + sme_pkg::LINK_SLOT, 32'(disp_rd(lev)));
                    mem_wr(old_top_q + sme_pkg::MARK_SIZE, 32'(base_q));
                    pc_q = wrap_pc(opd);
                end
                sme_pkg::OP_RETP: begin
                    top_q = wrap_idx(base_q - 1);
                    pc_q = wrap_pc(sx(mem_rd(top_q + 1)));
                    base_q = wrap_idx(sx(mem_rd(top_q + sme_pkg::MARK_SIZE)));
                end
                sme_pkg::OP_ENDP: stop_q = 1;
                sme_pkg::OP_UDIS: begin
                    h3 = base_q;
                    for (h1 = opd; h1 > lev; h1--) begin
                        disp_wr(h1, wrap_idx(h3));
                        h3 = sx(mem_rd(h3 + sme_pkg::LINK_SLOT));
                    end
                end
                sme_pkg::OP_OPAC: begin
                    old_top_q = top_q;
                    top_q = wrap_idx(top_q + sme_pkg::MARK_SIZE);
                end
                sme_pkg::OP_ENTP: begin
                    base_q = wrap_idx(old_top_q + 1);
                    disp_wr(lev, base_q);
                    top_q = wrap_idx(old_top_q + opd);
                end
                sme_pkg::OP_NOTS: mem_wr(top_q, ~mem_rd(top_q));
                sme_pkg::OP_MUS:  mem_wr(top_q, 32'd0 - mem_rd(top_q));
                default: begin
                    if (act >= sme_pkg::OP_ANDS && act <= sme_pkg::OP_GE) begin
                        v = 32'd0;
                        top_q = wrap_idx(top_q - 1);
                        a = sx(mem_rd(top_q));
                        b = sx(mem_rd(top_q + 1));
                        unique case (act)
                            sme_pkg::OP_ANDS: v = 32'(a) & 32'(b);
                            sme_pkg::OP_ORS:  v = 32'(a) | 32'(b);
                            sme_pkg::OP_IMOD: if (b == 0) flt_q = 1; else v = 32'(a % b);
                            sme_pkg::OP_ADD:  v = 32'(a + b);
                            sme_pkg::OP_SUB:  v = 32'(a - b);
                            sme_pkg::OP_MULT: v = 32'(a) * 32'(b);
                            sme_pkg::OP_IDIV: if (b == 0) flt_q = 1; else v = 32'(a / b);
                            sme_pkg::OP_EQ:   v = 32'(a == b);
                            sme_pkg::OP_NE:   v = 32'(a != b);
                            sme_pkg::OP_LS:   v = 32'(a < b);
                            sme_pkg::OP_LE:   v = 32'(a <= b);
                            sme_pkg::OP_GT:   v = 32'(a > b);
                            default:          v = 32'(a >= b);
                        endcase
                        mem_wr(top_q, v);
                    end
                end
            endcase
        end
        r.pc = pc_q[7:0];
        r.halt = stop_q;
        r.flt = flt_q;
        return r;
    endfunction

    initial begin
        forever #2 aclk = ~aclk;
    end

    // input side acceptance and prediction
    always @(posedge aclk) begin
        result_t p;
        if (s_tvalid && s_tready) begin
            p = execute_word(cur_word.act, cur_word.lev, cur_word.opd, cur_word.rv);
            pending_results.push_back(cur_word.typed ? cur_word.res : p);
            words_in++;
        end
    end

    // result side checking
    always @(posedge aclk) begin
        result_t e;
        if (m_tvalid && m_tready) begin
            if (pending_results.size() == 0) begin
                $error("result word with nothing expected");
                errors++;
            end else begin
                e = pending_results.pop_front();
                if (m_tdata[7:0] !== e.pc) begin
                    $error("next_pc exp %0d got %0d", e.pc, m_tdata[7:0]); errors++;
                end
                if (m_tdata[8] !== e.wv) begin
                    $error("write_valid exp %0d got %0d", e.wv, m_tdata[8]); errors++;
                end
                if (m_tdata[10:9] !== e.wm) begin
                    $error("write_mode exp %0d got %0d", e.wm, m_tdata[10:9]); errors++;
                end
                if (m_tdata[42:11] !== e.wval) begin
                    $error("write_value exp %h got %h", e.wval, m_tdata[42:11]); errors++;
                end
                if (m_tdata[43] !== e.halt) begin
                    $error("halted exp %0d got %0d", e.halt, m_tdata[43]); errors++;
                end
                if (m_tdata[44] !== e.flt) begin
                    $error("fault exp %0d got %0d", e.flt, m_tdata[44]); errors++;
                end
            end
        end
    end

    // watchdog on cycles without any handshake
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles = 0;
        else quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    always @(negedge aclk) begin
        m_tready <= no_idle ? 1'b1 : ($urandom_range(0, 99) >= 22);
    end

    task automatic send_word(row_t w);
        int seen;
        while (!no_idle && $urandom_range(0, 99) < 22) begin
            s_tvalid = 0;
            @(negedge aclk);
        end
        cur_word = w;
        s_tdata = {3'b000, w.rv, w.opd, w.lev, w.act};
        s_tvalid = 1;
        seen = words_in;
        do @(negedge aclk); while (words_in == seen);
    endtask

    function automatic row_t mk(logic [5:0] act, logic [3:0] lev, logic [10:0] opd,
                                logic [31:0] rv);
        row_t w;
        w.act = act; w.lev = lev; w.opd = opd; w.rv = rv;
        w.typed = 0;
        w.res = '{default: 0};
        return w;
    endfunction

    function automatic row_t mk_exp(logic [5:0] act, logic [3:0] lev, logic [10:0] opd,
                                    logic [7:0] pc, logic flt);
        row_t w;
        w = mk(act, lev, opd, 0);
        w.typed = 1;
        w.res.pc = pc;
        w.res.flt = flt;
        return w;
    endfunction

    function automatic row_t rand_word();
        int          r;
        logic [5:0]  act;
        logic [3:0]  lev;
        logic [10:0] opd;
        r = $urandom_range(0, 99);
        lev = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(0, 15))
                                          : 4'($urandom_range(0, 3));
        opd = ($urandom_range(0, 3) == 0) ? 11'($urandom) : 11'($urandom_range(0, 40));
        if (r < 30) act = sme_pkg::OP_LIT;
        else if (r < 33) act = 6'($urandom_range(33, 63));
        else begin
            do act = 6'($urandom_range(sme_pkg::OP_LOD, sme_pkg::OP_GE));
            while (act == sme_pkg::OP_ENDP);
        end
        if (act == sme_pkg::OP_LODB || act == sme_pkg::OP_CPYB || act == sme_pkg::OP_UDIS)
            opd = ($urandom_range(0, 49) == 0) ? 11'($urandom) : 11'($urandom_range(0, 8));
        if ((act == sme_pkg::OP_RED || act == sme_pkg::OP_WRT) && $urandom_range(0, 4) != 0)
            opd = 11'($urandom_range(0, 2));
        return mk(act, lev, opd, $urandom);
    endfunction

    row_t directed_words [] = '{
        mk_exp(sme_pkg::OP_LIT, 0, 11'd2047, 8'd1, 0),
        mk_exp(sme_pkg::OP_LIT, 0, 11'd0, 8'd2, 0),
        mk_exp(sme_pkg::OP_IDIV, 0, 11'd0, 8'd3, 1),
        mk_exp(sme_pkg::OP_LOD, 4'd15, 11'd0, 8'd4, 1),
        mk(sme_pkg::OP_LIT, 0, 11'd7, 0),
        mk(sme_pkg::OP_RED, 0, 11'd0, 32'h8000_0000),
        mk(sme_pkg::OP_LIT, 0, 11'd7, 0),
        mk(sme_pkg::OP_LODT, 0, 0, 0),
        mk(sme_pkg::OP_WRT, 0, 11'd0, 0),
        mk(sme_pkg::OP_LIT, 0, 11'd5, 0),
        mk(sme_pkg::OP_WRT, 0, 11'd3, 0),
        mk(sme_pkg::OP_LIT, 0, 11'd3, 0),
        mk(sme_pkg::OP_MUS, 0, 0, 0),
        mk(sme_pkg::OP_NOTS, 0, 0, 0),
        mk(sme_pkg::OP_LIT, 0, 11'd0, 0),
        mk(sme_pkg::OP_IMOD, 0, 0, 0),
        mk(sme_pkg::OP_OPAC, 0, 0, 0),
        mk(sme_pkg::OP_CAL, 1, 11'd40, 0),
        mk(sme_pkg::OP_ENTP, 1, 11'd5, 0),
        mk(sme_pkg::OP_UDIS, 0, 11'd2, 0),
        mk(sme_pkg::OP_LODA, 1, 11'd2, 0),
        mk(sme_pkg::OP_LODB, 0, 11'd3, 0),
        mk(sme_pkg::OP_RETP, 0, 0, 0),
        mk(sme_pkg::OP_JPC, 0, 11'd2047, 0),
        mk(sme_pkg::OP_JMP, 0, 11'd255, 0),
        mk(6'd63, 4'd15, 11'd2047, 32'hffff_ffff)
    };

    initial begin
        result_t p;
        for (int i = 0; i < sme_pkg::STACK_DEPTH; i++) mem_words[i] = 0;
        for (int i = 0; i < sme_pkg::LEVEL_COUNT; i++) disp_base[i] = 0;
        top_q = 0; base_q = 0; old_top_q = 0; pc_q = 0; stop_q = 0;
        repeat (9) @(negedge aclk);
        aresetn = 1;

        foreach (directed_words[i]) send_word(directed_words[i]);

        // hold off until the pipe has drained
        s_tvalid = 0;
        while (pending_results.size() != 0) @(negedge aclk);

        for (int i = 0; i < 1500; i++) begin
            no_idle = (i >= 400 && i < 700);
            send_word(rand_word());
        end
        no_idle = 0;

        send_word(mk(sme_pkg::OP_ENDP, 0, 0, 0));
        for (int i = 0; i < 4; i++) send_word(rand_word());
        s_tvalid = 0;

        while (pending_results.size() != 0) @(negedge aclk);
        repeat (60) @(negedge aclk);
        if (errors == 0 && pending_results.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

// ===== stack_machine_execute_unit.f =====
rtl/sme_pkg.sv
rtl/sme_ram.sv
rtl/stack_machine_execute_unit.sv
bench/stack_machine_execute_unit_test.sv
